### hdl/rpd_pkg.sv
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int MAX_PAYLOAD = 511;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int CHAR_W      = 8;
  localparam int INDEX_W     = 9;
  localparam int RES_N       = 3;
  localparam int TDATA_W     = 32;
  localparam int TUSER_W     = 5;

  localparam logic [CHAR_W-1:0] CH_START = 8'h24;  // '$'
  localparam logic [CHAR_W-1:0] CH_END   = 8'h23;  // '#'
  localparam logic [CHAR_W-1:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_NAK   = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;  // ':'

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_SUM_HI = 4'b0100,
    PH_SUM_LO = 4'b1000
  } phase_t;

  typedef struct packed {
    logic               host_valid;
    logic [CHAR_W-1:0]  host_char;
    logic               payload_valid;
    logic [CHAR_W-1:0]  payload_char;
    logic [INDEX_W-1:0] payload_index;
    logic               packet_done;
    logic               packet_good;
    logic               has_sequence_id;
    logic               last;
  } result_t;

endpackage

### hdl/rsp_packet_deframer_core.sv
`timescale 1ns / 1ps
// Packet deframer for the debugger remote serial link.
// s_axis carries one received character per item. The block drops
// characters until '$', forwards body characters as tentative payload,
// checks the two hex checksum digits after '#', and issues the verdict.
// m_axis carries one result per item: a payload character with its index,
// a packet verdict, with the '+' or '-' reply after a checksum, or an
// echoed sequence-id character; tlast marks the final result of one input
// character. A character passes through the input register, then its
// results through the result buffer. Throughput: one character per cycle
// while each yields at most one result and the receiver takes it; a good
// packet with a sequence id yields three results and holds the input
// until they drain through the single output port.
// Reset (rst, synchronous) returns the parser to hunting for '$' and
// empties the input register and the result buffer.
// When the receiver stalls, results wait in the buffer, one more
// character waits in the input register, and then s_axis_tready drops.

module rsp_packet_deframer_core import rpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [CHAR_W-1:0]  s_axis_tdata,   // rx_char
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // host_char, payload_char, payload_index, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata,
  // host_valid, payload_valid, packet_done, packet_good, has_sequence_id
  output logic [TUSER_W-1:0] m_axis_tuser,
  output logic               m_axis_tlast
);

  logic                 in_valid;
  logic [CHAR_W-1:0]    in_char;
  logic                 pop, buf_free, take;
  result_t [RES_N-1:0]  res;
  logic    [RES_N-1:0]  res_valid;
  result_t [RES_N-1:0]  res_buf;
  logic    [RES_N-1:0]  buf_valid;

  assign pop           = buf_valid[0] && m_axis_tready;
  assign buf_free      = !buf_valid[0] || (pop && !buf_valid[1]);
  assign take          = in_valid && buf_free;
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  rpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .rx_char   (in_char),
    .res       (res),
    .res_valid (res_valid)
  );

  // result buffer: loads all results of one character, drains from entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= '0;
    end else if (take) begin
      buf_valid <= res_valid;
    end else if (pop) begin
      buf_valid <= {1'b0, buf_valid[RES_N-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_buf <= res;
    end else if (pop) begin
      res_buf <= {result_t'('0), res_buf[RES_N-1:1]};
    end
  end

  assign m_axis_tvalid = buf_valid[0];
  assign m_axis_tlast  = res_buf[0].last;
  assign m_axis_tdata  = {(TDATA_W - 2 * CHAR_W - INDEX_W)'(0), res_buf[0].payload_index,
                          res_buf[0].payload_char, res_buf[0].host_char};
  assign m_axis_tuser  = {res_buf[0].has_sequence_id, res_buf[0].packet_good,
                          res_buf[0].packet_done, res_buf[0].payload_valid,
                          res_buf[0].host_valid};

endmodule

### hdl/rpd_parser.sv
`timescale 1ns / 1ps

module rpd_parser import rpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [CHAR_W-1:0]        rx_char,
  output result_t [RES_N-1:0]      res,
  output logic    [RES_N-1:0]      res_valid
);

  // bit 4 set for a character that is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  phase_t            phase, phase_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [CNT_W-1:0]  body_count, body_count_next;
  logic [3:0]        sent_sum_high, sent_sum_high_next;
  logic              sent_sum_bad, sent_sum_bad_next;
  logic [CHAR_W-1:0] first_chars [3];
  logic              fc_we;
  logic [4:0]        hex;
  logic [CNT_W-1:0]  cnt_inc;
  logic              good, seq;

  assign hex     = hex_decode(rx_char);
  assign cnt_inc = body_count + CNT_W'(1);
  assign good    = !sent_sum_bad && !hex[4] && ({sent_sum_high, hex[3:0]} == running_sum);
  assign seq     = good && (body_count >= CNT_W'(3)) && (first_chars[2] == CH_COLON);

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    body_count_next    = body_count;
    sent_sum_high_next = sent_sum_high;
    sent_sum_bad_next  = sent_sum_bad;
    fc_we              = 1'b0;
    res                = '0;
    res_valid          = '0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_char == CH_START) begin
          running_sum_next = '0;
          body_count_next  = '0;
          phase_next       = PH_BODY;
        end
      end
      PH_BODY: begin
        if (rx_char == CH_START) begin
          // restart: fail the open packet, begin a new body
          res[0].packet_done = 1'b1;
          res[0].last        = 1'b1;
          res_valid[0]       = 1'b1;
          running_sum_next   = '0;
          body_count_next    = '0;
        end else if (rx_char == CH_END) begin
          phase_next = PH_SUM_HI;
        end else begin
          running_sum_next     = running_sum + rx_char;
          fc_we                = (body_count < CNT_W'(3));
          body_count_next      = cnt_inc;
          res[0].payload_valid = 1'b1;
          res[0].payload_char  = rx_char;
          res[0].payload_index = INDEX_W'(body_count);
          res_valid[0]         = 1'b1;
          if (cnt_inc == CNT_W'(MAX_PAYLOAD)) begin
            // overflow: failing verdict follows the last body character
            res[1].packet_done = 1'b1;
            res[1].last        = 1'b1;
            res_valid[1]       = 1'b1;
            phase_next         = PH_HUNT;
          end else begin
            res[0].last = 1'b1;
          end
        end
      end
      PH_SUM_HI: begin
        sent_sum_bad_next  = hex[4];
        sent_sum_high_next = hex[3:0];
        phase_next         = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        res[0].host_valid      = 1'b1;
        res[0].host_char       = good ? CH_ACK : CH_NAK;
        res[0].packet_done     = 1'b1;
        res[0].packet_good     = good;
        res[0].has_sequence_id = seq;
        res_valid[0]           = 1'b1;
        if (seq) begin
          res[1].host_valid      = 1'b1;
          res[1].host_char       = first_chars[0];
          res[1].has_sequence_id = 1'b1;
          res_valid[1]           = 1'b1;
          res[2].host_valid      = 1'b1;
          res[2].host_char       = first_chars[1];
          res[2].has_sequence_id = 1'b1;
          res[2].last            = 1'b1;
          res_valid[2]           = 1'b1;
        end else begin
          res[0].last = 1'b1;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_sum   <= '0;
      body_count    <= '0;
      sent_sum_high <= '0;
      sent_sum_bad  <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      body_count    <= body_count_next;
      sent_sum_high <= sent_sum_high_next;
      sent_sum_bad  <= sent_sum_bad_next;
    end
  end

  // first three body characters, kept for the sequence-id check and echo
  always_ff @(posedge clk) begin
    if (step && fc_we) begin
      first_chars[body_count[1:0]] <= rx_char;
    end
  end

endmodule

### hdl/rpd_checker.sv
`timescale 1ns / 1ps

module rpd_checker import rpd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [CHAR_W-1:0]  s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [TUSER_W-1:0] m_axis_tuser,
  input logic               m_axis_tlast
);

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // an offered item holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata))
    else $error("offered item changed before it was taken");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a result is never both a reply character and a payload character
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("reply and payload in one result");

  // a good verdict is a done packet answered with an ack
  a_good_ack: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tuser[2] && m_axis_tuser[0] && (m_axis_tdata[CHAR_W-1:0] == CH_ACK))
    else $error("good verdict without ack");

endmodule

bind rsp_packet_deframer_core rpd_checker u_rpd_checker (.*);
